/* rtl/debounced_fault_input_monitor_top_assert.svh */
// Assertion macros for the debounced fault input monitor checker.
// Used by dfim_checker.sv; expects clk and arst_n in scope.
`ifndef DEBOUNCED_FAULT_INPUT_MONITOR_TOP_ASSERT_SVH
`define DEBOUNCED_FAULT_INPUT_MONITOR_TOP_ASSERT_SVH

// Check a clocked property, disabled while reset is asserted.
`define DFIM_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("dfim: property violated");

// Check that an expression never holds at a clock edge.
`define DFIM_NEVER(name, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("dfim: forbidden condition seen");

`endif

/* rtl/dfim_pkg.sv */
// Shared types, constants and helpers for the debounced fault input monitor.
// No dependencies; imported by dfim_chan_unit and the top level.
package dfim_pkg;

	localparam int CHANNELS = 5;
	localparam int CH_W = $clog2(CHANNELS);
	localparam int RUN_W = 4;
	localparam int FIRST_W = 3;
	localparam int TDATA_IN_W = 8;
	localparam int TDATA_OUT_W = 8;
	localparam logic [RUN_W-1:0] DEBOUNCE_RESET = 4'd3;

	typedef logic [RUN_W-1:0] run_t;

	// Result of one channel update from the shared counter unit
	typedef struct packed {
		run_t low_run;
		run_t high_run;
		logic low_hit;
		logic high_hit;
	} chan_upd_t;

	// Highest channel index set in the mask, 0 when empty
	function automatic logic [FIRST_W-1:0] highest_set(input logic [CHANNELS-1:0] m);
		logic [FIRST_W-1:0] r;
		r = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (m[i]) begin
				r = FIRST_W'(i);
			end
		end
		return r;
	endfunction

endpackage

/* rtl/dfim_chan_unit.sv */
// Shared run-counter unit: advances one channel's low/high run per cycle while the walk is not held.
// Depends on dfim_pkg for run_t and chan_upd_t.
module dfim_chan_unit import dfim_pkg::*; (
	input  logic      level,
	input  run_t      low_run,
	input  run_t      high_run,
	input  run_t      debounce,
	output chan_upd_t upd
);

	run_t lo_inc;
	run_t hi_inc;
	logic lo_hit;
	logic hi_hit;

	// Advance both candidates; only the one matching the level is kept
	assign lo_inc = low_run + run_t'(1);
	assign hi_inc = high_run + run_t'(1);
	assign lo_hit = (lo_inc >= debounce);
	assign hi_hit = (hi_inc >= debounce);

	// Clear the opposite run, restart the counter on a threshold hit
	always_comb begin
		if (!level) begin
			upd.high_run = '0;
			upd.low_run  = lo_hit ? '0 : lo_inc;
			upd.low_hit  = lo_hit;
			upd.high_hit = 1'b0;
		end else begin
			upd.low_run  = '0;
			upd.high_run = hi_hit ? '0 : hi_inc;
			upd.low_hit  = 1'b0;
			upd.high_hit = hi_hit;
		end
	end

endmodule

/* rtl/debounced_fault_input_monitor_top.sv */
// Debounced fault input monitor: each request on the slave stream carries one
// sampled level per channel (5 channels, 0 = fault level). The block walks the
// channels one per cycle through a single shared run-counter unit, holding on
// the last channel while the output is stalled. The result is registered on
// the master stream as the walk steps off the last channel. s_tready stays low
// during the walk and is high again in the same cycle that the result appears.
// A request is accepted while idle, then each channel is walked in turn. A
// result holds the latched fault mask and the first-fault index. If the
// previous result is still unclaimed when the walk reaches the last channel,
// the walk waits there until it is taken. The user must write debounce_count
// through cfg_we/cfg_wdata only while the block is idle; it is not enforced.
module debounced_fault_input_monitor_top import dfim_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [RUN_W-1:0]       cfg_wdata,     // debounce_count
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [TDATA_IN_W-1:0]  s_tdata,       // [4:0] pin_levels, [7:5] zero
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [TDATA_OUT_W-1:0] m_tdata        // [4:0] fault_mask, [7:5] first_fault
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WALK = 1'b1;
	localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

	logic                   state_q;
	logic [CH_W-1:0]        ch_q;
	logic [CHANNELS-1:0]    levels_q;
	run_t                   debounce_q;
	run_t                   low_run_q [CHANNELS];
	run_t                   high_run_q [CHANNELS];
	logic [CHANNELS-1:0]    mask_q;
	logic [FIRST_W-1:0]     first_q;
	logic                   m_tvalid_q;
	logic [TDATA_OUT_W-1:0] m_tdata_q;

	chan_upd_t              upd;
	logic                   out_free;
	logic                   step_en;
	logic                   last_ch;
	logic [CHANNELS-1:0]    mask_nx;
	logic [FIRST_W-1:0]     first_nx;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Shared counter unit, fed by the channel under the walk pointer
	dfim_chan_unit u_unit (
		.level    (levels_q[ch_q]),
		.low_run  (low_run_q[ch_q]),
		.high_run (high_run_q[ch_q]),
		.debounce (debounce_q),
		.upd      (upd)
	);

	// Hold the last channel until the output register can take the result
	assign out_free = !m_tvalid_q || m_tready;
	assign last_ch  = (ch_q == CH_LAST);
	assign step_en  = (state_q == ST_WALK) && (!last_ch || out_free);

	// Latch or release the current channel and track the first fault
	always_comb begin
		mask_nx  = mask_q;
		first_nx = first_q;
		if (upd.low_hit && !mask_q[ch_q]) begin
			mask_nx[ch_q] = 1'b1;
			if (first_q == '0) begin
				first_nx = FIRST_W'(ch_q);
			end
		end
		if (upd.high_hit && mask_q[ch_q]) begin
			mask_nx[ch_q] = 1'b0;
			first_nx      = highest_set(mask_nx);
		end
	end

	// Sequencer, channel state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ch_q       <= '0;
			debounce_q <= DEBOUNCE_RESET;
			mask_q     <= '0;
			first_q    <= '0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				low_run_q[i]  <= '0;
				high_run_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				debounce_q <= cfg_wdata;
			end
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_WALK;
						ch_q    <= '0;
					end
				end
				ST_WALK: begin
					if (step_en) begin
						low_run_q[ch_q]  <= upd.low_run;
						high_run_q[ch_q] <= upd.high_run;
						mask_q           <= mask_nx;
						first_q          <= first_nx;
						if (last_ch) begin
							state_q    <= ST_IDLE;
							m_tvalid_q <= 1'b1;
						end else begin
							ch_q <= ch_q + CH_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Capture the request levels and the result payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			levels_q <= s_tdata[CHANNELS-1:0];
		end
		if (step_en && last_ch) begin
			m_tdata_q <= {first_nx, mask_nx};
		end
	end

endmodule

/* rtl/dfim_checker.sv */
// Port-level checker for the debounced fault input monitor, bound to the top.
// Depends on debounced_fault_input_monitor_top_assert.svh for the macros.
`include "debounced_fault_input_monitor_top_assert.svh"

module dfim_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_we,
	input logic [3:0] cfg_wdata,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [7:0] s_tdata,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	// Stalled result holds its payload
	`DFIM_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

	// Accepting a request starts the channel walk, so ready drops
	`DFIM_ASSERT(a_busy_after_req, s_tvalid && s_tready |=> !s_tready)

	// First-fault index never points past the last channel
	`DFIM_NEVER(a_first_range, m_tvalid && (m_tdata[7:5] > 3'd4))

	// A nonzero first-fault index names a channel that is still latched
	`DFIM_ASSERT(a_first_in_mask,
		m_tvalid && (m_tdata[7:5] != 3'd0) |-> ((m_tdata[4:0] >> m_tdata[7:5]) & 5'd1) != 5'd0)

endmodule

bind debounced_fault_input_monitor_top dfim_checker u_dfim_checker (.*);

/* tb/debounced_fault_input_monitor_top_tb.sv */
// Testbench for debounced_fault_input_monitor_top: drives sampled pin levels,
// predicts the latched fault mask and first-fault index, checks every result.
// Depends on dfim_pkg and the top level RTL only.
module debounced_fault_input_monitor_top_tb;
	import dfim_pkg::*;

	localparam int LIMIT_CYCLES = 400000;

	typedef struct packed {
		logic [CHANNELS-1:0] mask;
		logic [FIRST_W-1:0]  first;
	} fault_status_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [RUN_W-1:0]       cfg_wdata;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [TDATA_IN_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [TDATA_OUT_W-1:0] m_tdata;

	// predicted block state
	logic [RUN_W-1:0]    low_cnt [CHANNELS];
	logic [RUN_W-1:0]    high_cnt [CHANNELS];
	logic                latch_q [CHANNELS];
	logic [CHANNELS-1:0] mask_q;
	logic [FIRST_W-1:0]  first_q;
	logic [RUN_W-1:0]    threshold;

	fault_status_t fault_status_q[$];

	int  err_count;
	int  requests_sent;
	int  results_checked;
	int  latch_events;
	int  clear_events;
	int  settings_used;
	int  cycle_count;
	int  sink_wait;
	bit  steady;

	debounced_fault_input_monitor_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
	end

	// Idle length: mostly none, often short, now and then long
	function automatic int idle_len();
		int r;
		if (steady) begin
			return 0;
		end
		r = $urandom_range(99);
		if (r < 60) begin
			return 0;
		end
		if (r < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// Advance every channel by one tick and queue the resulting status
	function automatic void debounce_tick(input logic [CHANNELS-1:0] pins);
		for (int ch = 0; ch < CHANNELS; ch++) begin
			if (!pins[ch]) begin
				high_cnt[ch] = '0;
				low_cnt[ch] = low_cnt[ch] + 1'b1;
				if (low_cnt[ch] >= threshold) begin
					if (!latch_q[ch]) begin
						latch_q[ch] = 1'b1;
						mask_q[ch] = 1'b1;
						latch_events++;
						if (first_q == '0) begin
							first_q = FIRST_W'(ch);
						end
					end
					low_cnt[ch] = '0;
				end
			end else begin
				low_cnt[ch] = '0;
				high_cnt[ch] = high_cnt[ch] + 1'b1;
				if (high_cnt[ch] >= threshold) begin
					if (latch_q[ch]) begin
						latch_q[ch] = 1'b0;
						mask_q[ch] = 1'b0;
						clear_events++;
						// fall back to the highest channel still faulted
						first_q = '0;
						for (int k = 0; k < CHANNELS; k++) begin
							if (mask_q[k]) begin
								first_q = FIRST_W'(k);
							end
						end
					end
					high_cnt[ch] = '0;
				end
			end
		end
		fault_status_q.push_back('{mask: mask_q, first: first_q});
	endfunction

	// Send one request; valid stays high afterwards unless a gap follows
	task automatic send_levels(input logic [CHANNELS-1:0] pins);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= TDATA_IN_W'(pins);
		do @(posedge clk); while (!s_tready);
		debounce_tick(pins);
		requests_sent++;
	endtask

	// Drop valid and wait until every expected result has come back
	task automatic settle();
		s_tvalid <= 1'b0;
		while (fault_status_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_threshold(input logic [RUN_W-1:0] value);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		threshold = value;
		settings_used++;
	endtask

	// Per-channel runs around the threshold, with some stray glitches
	task automatic run_phase(input logic [RUN_W-1:0] thr, input int n);
		logic [CHANNELS-1:0] level;
		int left [CHANNELS];
		int span;
		span = (thr == 0) ? 1 : int'(thr);
		level = CHANNELS'($urandom);
		for (int ch = 0; ch < CHANNELS; ch++) begin
			left[ch] = $urandom_range(1, span + 3);
		end
		for (int i = 0; i < n; i++) begin
			for (int ch = 0; ch < CHANNELS; ch++) begin
				if (left[ch] == 0) begin
					level[ch] = ~level[ch];
					if ($urandom_range(3) == 0) begin
						left[ch] = $urandom_range(1, span);
					end else begin
						left[ch] = $urandom_range(span, span + 3);
					end
				end
				left[ch]--;
			end
			if ($urandom_range(9) == 0) begin
				send_levels(level ^ CHANNELS'($urandom_range(1, 31)));
			end else begin
				send_levels(level);
			end
		end
	endtask

	// Reset threshold of three: latch all channels, then clear them
	task automatic test_default_threshold();
		repeat (3) send_levels('0);
		repeat (3) send_levels('1);
	endtask

	// Channel zero as first fault is overwritten by a later fault
	task automatic test_channel_zero_first();
		set_threshold(4'd1);
		send_levels(5'b11110);
		send_levels(5'b11100);
	endtask

	// Threshold zero: every sample triggers
	task automatic test_threshold_zero();
		set_threshold(4'd0);
		send_levels(5'b01010);
		send_levels(5'b10101);
		send_levels(5'b11111);
	endtask

	// Largest threshold: counters climb to fifteen and restart
	task automatic test_long_threshold();
		set_threshold(4'd15);
		repeat (15) send_levels('0);
	endtask

	task automatic test_random_thresholds();
		logic [RUN_W-1:0] plan [8];
		plan = '{4'd1, 4'd15, 4'd2, 4'd5, 4'd0, RUN_W'($urandom_range(1, 15)), 4'd8,
			RUN_W'($urandom_range(1, 15))};
		foreach (plan[p]) begin
			set_threshold(plan[p]);
			run_phase(plan[p], 140);
		end
	endtask

	// Back-to-back traffic with no idling on either side
	task automatic test_back_to_back();
		set_threshold(4'd2);
		steady = 1'b1;
		run_phase(4'd2, 100);
		steady = 1'b0;
	endtask

	// Result sink with random stalls
	always @(posedge clk) begin
		if (sink_wait > 0) begin
			sink_wait--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(3) == 0) begin
				sink_wait = idle_len();
			end
		end
	end

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		fault_status_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_checked++;
			if (fault_status_q.size() == 0) begin
				$error("result 0x%02h arrived with nothing expected", m_tdata);
				err_count++;
			end else begin
				want = fault_status_q.pop_front();
				if (m_tdata[CHANNELS-1:0] !== want.mask) begin
					$error("fault_mask expected 0x%02h actual 0x%02h",
						want.mask, m_tdata[CHANNELS-1:0]);
					err_count++;
				end
				if (m_tdata[CHANNELS +: FIRST_W] !== want.first) begin
					$error("first_fault expected %0d actual %0d",
						want.first, m_tdata[CHANNELS +: FIRST_W]);
					err_count++;
				end
			end
		end
	end

	// Hang guard
	initial begin
		while (cycle_count < LIMIT_CYCLES) @(posedge clk);
		$display("timeout after %0d cycles, %0d results outstanding",
			cycle_count, fault_status_q.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		sink_wait = 0;
		steady = 1'b0;
		err_count = 0;
		requests_sent = 0;
		results_checked = 0;
		latch_events = 0;
		clear_events = 0;
		settings_used = 0;
		cycle_count = 0;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			low_cnt[ch] = '0;
			high_cnt[ch] = '0;
			latch_q[ch] = 1'b0;
		end
		mask_q = '0;
		first_q = '0;
		threshold = DEBOUNCE_RESET;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_threshold();
		test_channel_zero_first();
		test_threshold_zero();
		test_long_threshold();
		test_random_thresholds();
		test_back_to_back();
		settle();
		repeat (20) @(posedge clk);

		$display("%0d sample requests over %0d threshold writes, %0d results checked",
			requests_sent, settings_used, results_checked);
		$display("%0d fault latches and %0d fault clears predicted", latch_events,
			clear_events);
		if (err_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
